>>> src/dsd_pkg.sv
// Package for the DST stitch decoder: weights, pipeline depth, stage types and
// the shared square-root step. No dependencies.
package dsd_pkg;

  // Balanced-ternary flag weights
  localparam logic [7:0] W1  = 8'd1;
  localparam logic [7:0] W3  = 8'd3;
  localparam logic [7:0] W9  = 8'd9;
  localparam logic [7:0] W27 = 8'd27;
  localparam logic [7:0] W81 = 8'd81;

  localparam int RAD_W   = 16;  // radicand, x^2 + y^2 <= 29282
  localparam int REM_W   = 10;  // partial remainder
  localparam int ROOT_W  = 8;   // result bits
  localparam int SQ_W    = 14;  // one square, <= 14641
  localparam int SQRT_ST = 4;   // sqrt stages, two result bits each
  localparam int NSTG    = 3 + SQRT_ST;  // decode, square, sum, sqrt

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic signed [7:0] step_x;
    logic signed [7:0] step_y;
    sq_t               sq;
  } pipe_t;

  // One digit of the restoring square root: bring in two radicand bits,
  // try to subtract 4*root+1, shift the outcome into the root.
  function automatic sq_t sqrt_step(input sq_t s);
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic             ge;
    sq_t              o;
    cur   = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial = (REM_W+2)'({s.root, 2'b01});
    ge    = (cur >= trial);
    o.rad  = {s.rad[RAD_W-3:0], 2'b00};
    o.rem  = ge ? REM_W'(cur - trial) : REM_W'(cur);
    o.root = {s.root[ROOT_W-2:0], ge};
    return o;
  endfunction

endpackage

>>> src/dst_stitch_decode_length.sv
// DST stitch decoder with stitch length: each input transaction passes the decode,
// square, sum and four two-digit sqrt stages to the result. Throughput one record
// per cycle while the output is not stalled; each stage holds while the one after
// it is full and stalled, so bubbles fill in and nothing is dropped or repeated.
// rst_n (synchronous, active low) clears all stage valid bits; data regs keep.
module dst_stitch_decode_length (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] rec_byte0, [15:8] rec_byte1, [23:16] rec_byte2
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [7:0] step_x, [15:8] step_y, [23:16] step_length
);

  localparam int N = dsd_pkg::NSTG;

  // Valid bit per stage and the load enable of each stage.
  logic [N-1:0] v_r, v_nxt;
  logic [N-1:0] en;
  logic [N-1:0] src_v;   // valid presented to each stage's input

  logic signed [7:0] dec_x, dec_y;
  dsd_pkg::pipe_t    sq_pipe;
  dsd_pkg::pipe_t    st_pipe [dsd_pkg::SQRT_ST+1];

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    en[N-1] = !v_r[N-1] || out_tready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    src_v[0] = in_tvalid;
    for (int k = 1; k < N; k++) begin
      src_v[k] = v_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      v_nxt[k] = en[k] ? src_v[k] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready = en[0];

  // Stage 0: flag decode
  dsd_decode u_decode (
    .clk       (clk),
    .en        (en[0]),
    .rec_byte0 (in_tdata[7:0]),
    .rec_byte1 (in_tdata[15:8]),
    .rec_byte2 (in_tdata[23:16]),
    .step_x    (dec_x),
    .step_y    (dec_y)
  );

  // Stages 1-2: squares, then their sum
  dsd_square u_square (
    .clk      (clk),
    .en       (en[2:1]),
    .step_x   (dec_x),
    .step_y   (dec_y),
    .pipe_out (sq_pipe)
  );

  assign st_pipe[0] = sq_pipe;

  // Stages 3-6: integer square root, two result bits per stage
  for (genvar g = 0; g < dsd_pkg::SQRT_ST; g++) begin : g_sqrt
    dsd_sqrt_stage u_stage (
      .clk      (clk),
      .en       (en[3+g]),
      .pipe_in  (st_pipe[g]),
      .pipe_out (st_pipe[g+1])
    );
  end

  assign out_tvalid = v_r[N-1];
  assign out_tdata  = {st_pipe[dsd_pkg::SQRT_ST].sq.root,
                       st_pipe[dsd_pkg::SQRT_ST].step_y,
                       st_pipe[dsd_pkg::SQRT_ST].step_x};

  // Checks
  logic [8:0]  len_w;
  logic [17:0] lsq, l1sq, ssum;
  assign len_w = {1'b0, out_tdata[23:16]};
  assign lsq   = 18'(len_w * len_w);
  assign l1sq  = 18'((len_w + 9'd1) * (len_w + 9'd1));
  assign ssum  = 18'($signed(out_tdata[7:0]) * $signed(out_tdata[7:0]))
               + 18'($signed(out_tdata[15:8]) * $signed(out_tdata[15:8]));

  a_len_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (lsq <= ssum) && (l1sq > ssum))
    else $error("stitch length is not the floor root of x^2+y^2");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r == '0) |-> in_tready)
    else $error("empty pipeline refuses input");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[7:0]) >= -8'sd121) && ($signed(out_tdata[7:0]) <= 8'sd121)
               && ($signed(out_tdata[15:8]) >= -8'sd121)
               && ($signed(out_tdata[15:8]) <= 8'sd121))
    else $error("step outside balanced-ternary range");

  a_count_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !(out_tvalid && out_tready)) |=> (v_r != '0))
    else $error("accepted transaction vanished");

endmodule

>>> src/dsd_decode.sv
// Decode stage: stitch record bytes to signed x and y steps.
// Depends on dsd_pkg.
module dsd_decode (
  input  logic              clk,
  input  logic              en,
  input  logic [7:0]        rec_byte0,
  input  logic [7:0]        rec_byte1,
  input  logic [7:0]        rec_byte2,
  output logic signed [7:0] step_x,
  output logic signed [7:0] step_y
);

  logic [7:0] xp, xn, yp, yn;
  logic signed [7:0] step_x_r, step_y_r;

  always_comb begin
    xp = (rec_byte0[0] ? dsd_pkg::W1 : 8'd0) + (rec_byte1[0] ? dsd_pkg::W3 : 8'd0)
       + (rec_byte0[2] ? dsd_pkg::W9 : 8'd0) + (rec_byte1[2] ? dsd_pkg::W27 : 8'd0)
       + (rec_byte2[2] ? dsd_pkg::W81 : 8'd0);
    xn = (rec_byte0[1] ? dsd_pkg::W1 : 8'd0) + (rec_byte1[1] ? dsd_pkg::W3 : 8'd0)
       + (rec_byte0[3] ? dsd_pkg::W9 : 8'd0) + (rec_byte1[3] ? dsd_pkg::W27 : 8'd0)
       + (rec_byte2[3] ? dsd_pkg::W81 : 8'd0);
    yp = (rec_byte0[7] ? dsd_pkg::W1 : 8'd0) + (rec_byte1[7] ? dsd_pkg::W3 : 8'd0)
       + (rec_byte0[5] ? dsd_pkg::W9 : 8'd0) + (rec_byte1[5] ? dsd_pkg::W27 : 8'd0)
       + (rec_byte2[5] ? dsd_pkg::W81 : 8'd0);
    yn = (rec_byte0[6] ? dsd_pkg::W1 : 8'd0) + (rec_byte1[6] ? dsd_pkg::W3 : 8'd0)
       + (rec_byte0[4] ? dsd_pkg::W9 : 8'd0) + (rec_byte1[4] ? dsd_pkg::W27 : 8'd0)
       + (rec_byte2[4] ? dsd_pkg::W81 : 8'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      step_x_r <= $signed(xp - xn);
      step_y_r <= $signed(yp - yn);
    end
  end

  assign step_x = step_x_r;
  assign step_y = step_y_r;

endmodule

>>> src/dsd_square.sv
// Square and sum stages: x^2 and y^2 in one stage, their sum and the sqrt
// start state in the next. Depends on dsd_pkg.
module dsd_square (
  input  logic              clk,
  input  logic [1:0]        en,       // [0] square stage, [1] sum stage
  input  logic signed [7:0] step_x,
  input  logic signed [7:0] step_y,
  output dsd_pkg::pipe_t    pipe_out
);

  logic signed [15:0]          px, py;
  logic [dsd_pkg::SQ_W-1:0]    xx_r, yy_r;
  logic signed [7:0]           x_r, y_r;
  dsd_pkg::pipe_t              pipe_r;

  assign px = step_x * step_x;
  assign py = step_y * step_y;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xx_r <= px[dsd_pkg::SQ_W-1:0];
      yy_r <= py[dsd_pkg::SQ_W-1:0];
      x_r  <= step_x;
      y_r  <= step_y;
    end
    if (en[1]) begin
      pipe_r.step_x  <= x_r;
      pipe_r.step_y  <= y_r;
      pipe_r.sq.rad  <= dsd_pkg::RAD_W'(xx_r) + dsd_pkg::RAD_W'(yy_r);
      pipe_r.sq.rem  <= '0;
      pipe_r.sq.root <= '0;
    end
  end

  assign pipe_out = pipe_r;

endmodule

>>> src/dsd_sqrt_stage.sv
// One square-root stage: two root digits, with the steps carried alongside.
// Depends on dsd_pkg.
module dsd_sqrt_stage (
  input  logic           clk,
  input  logic           en,
  input  dsd_pkg::pipe_t pipe_in,
  output dsd_pkg::pipe_t pipe_out
);

  dsd_pkg::pipe_t pipe_r;
  dsd_pkg::sq_t   mid;

  assign mid = dsd_pkg::sqrt_step(pipe_in.sq);

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r.step_x <= pipe_in.step_x;
      pipe_r.step_y <= pipe_in.step_y;
      pipe_r.sq     <= dsd_pkg::sqrt_step(mid);
    end
  end

  assign pipe_out = pipe_r;

endmodule
